### design/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types, constants and elaboration-time helpers for the lunar
// position pipeline.
// ----------------------------------------------------------------------------
package lpd_pkg;

   // angle and output formats
   localparam int ANGLE_BITS        = 32;
   localparam int OUT_FRACTION_BITS = 16;
   localparam int LON_SHIFT         = ANGLE_BITS - OUT_FRACTION_BITS;
   localparam int AMP_SHIFT         = 30 - OUT_FRACTION_BITS;

   typedef logic [ANGLE_BITS-1:0] angle_type;
   typedef logic signed [24:0]    half_days_type;

   // phase indexes
   localparam int NUM_PHASES = 3;
   localparam int PH_LON     = 0;
   localparam int PH_ANOM    = 1;
   localparam int PH_NODE    = 2;

   // pipeline depth of one sine lane
   localparam int SINE_LAT     = 8;
   localparam int HORNER_STEPS = 5;

   localparam logic [31:0] HORNER_P0 = 32'd3864;
   localparam logic [31:0] HORNER_C [HORNER_STEPS] = '{
      32'd172272, 32'd5026995, 32'd85569306, 32'd693598668, 32'd1686629713
   };
   localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
   localparam angle_type   QUARTER_TURN = angle_type'(1) << (ANGLE_BITS - 2);

   // amplitude scaling
   localparam logic [12:0] AMP_LON      = 13'd6289;
   localparam logic [12:0] AMP_LAT      = 13'd5128;
   localparam logic [14:0] AMP_DIST     = 15'd20905;
   localparam logic [45:0] HALF_ROUND   = 46'd500 << AMP_SHIFT;
   localparam int          DIST_SHIFT   = 26;
   localparam logic [46:0] DIST_ROUND   = 47'd1 << (DIST_SHIFT - 1);
   localparam logic [29:0] DIV1000_MUL  = 30'd549755814;
   localparam int          DIV1000_SHIFT = 39;
   localparam logic [22:0] DIST_BASE    = 23'd6160016;

   // date constants
   localparam logic signed [26:0] JD2_BIAS  = 27'sd3049;
   localparam logic signed [26:0] EPOCH_JD2 = 27'sd4903090;

   // binary fraction num/den of a turn, long division at elaboration
   function automatic logic [63:0] frac_turn(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] r;
      logic [63:0] q;
      r = {1'b0, num};
      q = '0;
      for (int i = 0; i < 64; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= {1'b0, den}) begin
            r = r - {1'b0, den};
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   localparam logic [63:0] PHASE_OFF [NUM_PHASES] = '{
      frac_turn(64'd218316, 64'd360000),
      frac_turn(64'd134963, 64'd360000),
      frac_turn(64'd93272,  64'd360000)
   };
   localparam logic [63:0] PHASE_RATE [NUM_PHASES] = '{
      frac_turn(64'd13176396, 64'd720000000),
      frac_turn(64'd13064993, 64'd720000000),
      frac_turn(64'd13229350, 64'd720000000)
   };

   // floor(30.6001 * (m + 1)) for the shifted month
   function automatic logic [8:0] month_offset(input logic [3:0] m);
      logic [8:0] v;
      unique case (m)
         4'd3:    v = 9'd122;
         4'd4:    v = 9'd153;
         4'd5:    v = 9'd183;
         4'd6:    v = 9'd214;
         4'd7:    v = 9'd244;
         4'd8:    v = 9'd275;
         4'd9:    v = 9'd306;
         4'd10:   v = 9'd336;
         4'd11:   v = 9'd367;
         4'd12:   v = 9'd397;
         4'd13:   v = 9'd428;
         4'd14:   v = 9'd459;
         4'd15:   v = 9'd489;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

   // delayed side data next to the sine lanes
   typedef struct packed {
      logic [23:0] jd2;
      angle_type   la;
   } tap_type;

endpackage

### design/lpd_if.sv
// ----------------------------------------------------------------------------
// lpd_if
// Request and response channels of the lunar position pipeline.
// ----------------------------------------------------------------------------
interface lpd_req_if;
   logic        valid;
   logic        ready;
   logic [13:0] year;
   logic [3:0]  month;
   logic [4:0]  day;

   modport source (output valid, year, month, day, input ready);
   modport sink   (input valid, year, month, day, output ready);
endinterface

interface lpd_rsp_if;
   logic               valid;
   logic               ready;
   logic [23:0]        julian_date_doubled;
   logic signed [25:0] ecliptic_longitude;
   logic signed [19:0] ecliptic_latitude;
   logic [22:0]        moon_distance;

   modport source (output valid, julian_date_doubled, ecliptic_longitude,
                   ecliptic_latitude, moon_distance, input ready);
   modport sink   (input valid, julian_date_doubled, ecliptic_longitude,
                   ecliptic_latitude, moon_distance, output ready);
endinterface

### design/lunar_position_from_date_top.sv
// pipeline stages: date 2, phase 2, sine 8, scale 3
// throughput: one request per cycle while the response is not stalled; no stage is more than one multiplier deep
// a stalled response holds the whole pipeline, nothing is dropped or repeated
// reset: synchronous, active high; clears all valid bits, no clearing pass
// ----------------------------------------------------------------------------
// lunar_position_from_date_top
// Calendar date to doubled Julian date and low-precision lunar position.
// ----------------------------------------------------------------------------
module lunar_position_from_date_top import lpd_pkg::*; (
   input logic       clock,
   input logic       reset,
   lpd_req_if.sink   req,
   lpd_rsp_if.source rsp
);

   logic          en;
   logic          date_v, phase_v, scale_v;
   logic [23:0]   date_jd2, phase_jd2;
   half_days_type date_h;
   angle_type     angle [NUM_PHASES];
   angle_type     cos_angle;
   logic [2:0]    sine_v;
   logic [31:0]   mag_m, mag_f, mag_c;
   logic          neg_m, neg_f, neg_c;
   tap_type       tap_ff [SINE_LAT];

   // global advance: move when the output slot is free or being taken
   assign en        = !rsp.valid || rsp.ready;
   assign req.ready = en;
   assign cos_angle = angle[PH_ANOM] + QUARTER_TURN;

   lpd_date u_date (
      .clock(clock), .reset(reset), .en(en), .in_valid(req.valid),
      .year(req.year), .month(req.month), .day(req.day),
      .out_valid(date_v), .jd2(date_jd2), .h(date_h)
   );

   lpd_phase u_phase (
      .clock(clock), .reset(reset), .en(en), .in_valid(date_v),
      .jd2_in(date_jd2), .h(date_h),
      .out_valid(phase_v), .jd2_out(phase_jd2), .angle(angle)
   );

   lpd_sine u_sin_m (
      .clock(clock), .reset(reset), .en(en), .in_valid(phase_v),
      .a(angle[PH_ANOM]), .out_valid(sine_v[0]), .mag(mag_m), .neg(neg_m)
   );

   lpd_sine u_sin_f (
      .clock(clock), .reset(reset), .en(en), .in_valid(phase_v),
      .a(angle[PH_NODE]), .out_valid(sine_v[1]), .mag(mag_f), .neg(neg_f)
   );

   lpd_sine u_cos_m (
      .clock(clock), .reset(reset), .en(en), .in_valid(phase_v),
      .a(cos_angle), .out_valid(sine_v[2]), .mag(mag_c), .neg(neg_c)
   );

   // side data delayed alongside the sine lanes
   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= '{jd2: phase_jd2, la: angle[PH_LON]};
         for (int s = 1; s < SINE_LAT; s++) begin
            tap_ff[s] <= tap_ff[s-1];
         end
      end
   end

   lpd_scale u_scale (
      .clock(clock), .reset(reset), .en(en), .in_valid(&sine_v),
      .jd2(tap_ff[SINE_LAT-1].jd2), .la(tap_ff[SINE_LAT-1].la),
      .mag_m(mag_m), .neg_m(neg_m), .mag_f(mag_f), .neg_f(neg_f),
      .mag_c(mag_c), .neg_c(neg_c),
      .out_valid(scale_v), .jd2_out(rsp.julian_date_doubled),
      .lon(rsp.ecliptic_longitude), .lat(rsp.ecliptic_latitude),
      .distance(rsp.moon_distance)
   );

   assign rsp.valid = scale_v;

`ifndef SYNTHESIS
   // response slot is empty after reset
   a_reset_clears : assert property (@(posedge clock) reset |=> !rsp.valid)
      else $error("response valid after reset");

   // doubled julian date carries the half day
   a_jd_odd : assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.julian_date_doubled[0])
      else $error("doubled julian date is even");

   // distance stays within the amplitude band
   a_dist_band : assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.moon_distance >= 23'd5825536 &&
                     rsp.moon_distance <= 23'd6494496))
      else $error("moon distance out of band");
`endif

endmodule

### design/lpd_date.sv
// ----------------------------------------------------------------------------
// lpd_date
// Two stages: calendar date to doubled Julian date and half-days since J2000.
// ----------------------------------------------------------------------------
module lpd_date import lpd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [13:0]   year,
   input  logic [3:0]    month,
   input  logic [4:0]    day,
   output logic          out_valid,
   output logic [23:0]   jd2,
   output half_days_type h
);

   logic               early;
   logic signed [15:0] ys;
   logic [14:0]        yo;
   logic [13:0]        yp;
   logic [3:0]         mm;
   logic [25:0]        a_prod;
   logic [26:0]        c_prod;
   logic [23:0]        a_in, a_ff;
   logic [7:0]         cent_in, cent_ff;
   logic [9:0]         bd_in, bd_ff;
   logic               va_ff, vb_ff;
   logic signed [9:0]  corr_s;
   logic signed [26:0] sum_s, jd_s, h_s;

   // shifted year and month, products
   always_comb begin
      early   = (month <= 4'd2);
      ys      = early ? $signed({2'b0, year}) - 16'sd1 : $signed({2'b0, year});
      mm      = early ? month + 4'd12 : month;
      yo      = 15'(ys + 16'sd4716);
      yp      = ys[15] ? 14'd0 : ys[13:0];
      a_prod  = 26'(yo) * 26'd1461;
      c_prod  = 27'(yp) * 27'd5243;
      a_in    = a_prod[25:2];
      cent_in = c_prod[26:19];
      bd_in   = 10'(month_offset(mm)) + 10'(day);
   end

   // century correction and sums
   always_comb begin
      corr_s = 10'sd2 - $signed({2'b0, cent_ff}) + $signed({4'b0, cent_ff[7:2]});
      sum_s  = $signed({3'b0, a_ff}) + $signed({17'b0, bd_ff}) + 27'(corr_s);
      jd_s   = (sum_s <<< 1) - JD2_BIAS;
      h_s    = jd_s - EPOCH_JD2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff    <= a_in;
         cent_ff <= cent_in;
         bd_ff   <= bd_in;
         jd2     <= jd_s[23:0];
         h       <= h_s[24:0];
      end
   end

   assign out_valid = vb_ff;

endmodule

### design/lpd_phase.sv
// ----------------------------------------------------------------------------
// lpd_phase
// Two stages: partial products and wrap-around sums of the three phases.
// ----------------------------------------------------------------------------
module lpd_phase import lpd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [23:0]   jd2_in,
   input  half_days_type h,
   output logic          out_valid,
   output logic [23:0]   jd2_out,
   output angle_type     angle [NUM_PHASES]
);

   logic signed [57:0] lo_in [NUM_PHASES];
   logic signed [57:0] lo_ff [NUM_PHASES];
   logic signed [57:0] hi_full [NUM_PHASES];
   logic [31:0]        hi_ff [NUM_PHASES];
   logic [63:0]        ph [NUM_PHASES];
   logic [23:0]        jd2_ff;
   logic               vc_ff, vd_ff;

   // split rate products, low 64 bits kept
   always_comb begin
      for (int i = 0; i < NUM_PHASES; i++) begin
         lo_in[i]   = h * $signed({1'b0, PHASE_RATE[i][31:0]});
         hi_full[i] = h * $signed({1'b0, PHASE_RATE[i][63:32]});
         ph[i]      = PHASE_OFF[i] + 64'(lo_ff[i]) + {hi_ff[i], 32'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else if (en) begin
         vc_ff <= in_valid;
         vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         jd2_ff  <= jd2_in;
         jd2_out <= jd2_ff;
         for (int i = 0; i < NUM_PHASES; i++) begin
            lo_ff[i] <= lo_in[i];
            hi_ff[i] <= hi_full[i][31:0];
            angle[i] <= ph[i][63 -: ANGLE_BITS];
         end
      end
   end

   assign out_valid = vd_ff;

endmodule

### design/lpd_sine.sv
// ----------------------------------------------------------------------------
// lpd_sine
// One sine lane: quadrant fold, square, Horner steps one per stage, final
// product. Returns magnitude in Q30 and the sign.
// ----------------------------------------------------------------------------
module lpd_sine import lpd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  angle_type   a,
   output logic        out_valid,
   output logic [31:0] mag,
   output logic        neg
);

   logic [SINE_LAT-1:0] v_ff;
   logic [30:0]         x_in;
   logic [30:0]         x_ff [SINE_LAT-1];
   logic                neg_ff [SINE_LAT-1];
   logic [30:0]         x2_ff [HORNER_STEPS];
   logic [31:0]         p_ff [HORNER_STEPS];
   logic [61:0]         sq;
   logic [31:0]         hin [HORNER_STEPS];
   logic [62:0]         hprod [HORNER_STEPS];
   logic [62:0]         fprod;

   // fold into the first quadrant
   always_comb begin
      x_in = a[ANGLE_BITS-2] ? Q30_ONE - {1'b0, a[ANGLE_BITS-3 -: 30]}
                             : {1'b0, a[ANGLE_BITS-3 -: 30]};
   end

   // square and Horner terms
   always_comb begin
      sq     = 62'(x_ff[0]) * 62'(x_ff[0]);
      hin[0] = HORNER_P0;
      for (int k = 1; k < HORNER_STEPS; k++) begin
         hin[k] = p_ff[k-1];
      end
      for (int k = 0; k < HORNER_STEPS; k++) begin
         hprod[k] = 63'(x2_ff[k]) * 63'(hin[k]);
      end
      fprod = 63'(x_ff[SINE_LAT-2]) * 63'(p_ff[HORNER_STEPS-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[SINE_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]   <= x_in;
         neg_ff[0] <= a[ANGLE_BITS-1];
         for (int s = 1; s < SINE_LAT-1; s++) begin
            x_ff[s]   <= x_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
         end
         x2_ff[0] <= sq[60:30];
         for (int k = 1; k < HORNER_STEPS; k++) begin
            x2_ff[k] <= x2_ff[k-1];
         end
         for (int k = 0; k < HORNER_STEPS; k++) begin
            p_ff[k] <= HORNER_C[k] - hprod[k][61:30];
         end
         mag <= fprod[61:30];
         neg <= neg_ff[SINE_LAT-2];
      end
   end

   assign out_valid = v_ff[SINE_LAT-1];

endmodule

### design/lpd_scale.sv
// ----------------------------------------------------------------------------
// lpd_scale
// Three stages: amplitude products, rounding and division by a thousand,
// sign and final sums.
// ----------------------------------------------------------------------------
module lpd_scale import lpd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [23:0]        jd2,
   input  angle_type          la,
   input  logic [31:0]        mag_m,
   input  logic               neg_m,
   input  logic [31:0]        mag_f,
   input  logic               neg_f,
   input  logic [31:0]        mag_c,
   input  logic               neg_c,
   output logic               out_valid,
   output logic [23:0]        jd2_out,
   output logic signed [25:0] lon,
   output logic signed [19:0] lat,
   output logic [22:0]        distance
);

   logic [2:0]  v_ff;
   logic [23:0] jd2_e_ff, jd2_f_ff;
   logic [2:0]  neg_e_ff, neg_f_ff;
   logic [40:0] lonp_ff;
   logic [45:0] nl_ff, nb_ff;
   logic [46:0] nd_ff;
   logic [61:0] ql_ff, qb_ff;
   logic [24:0] lonq_ff;
   logic [20:0] td_ff;
   logic [31:0] vl, vb;
   logic [22:0] tl, tb;
   logic signed [25:0] tls;
   logic signed [19:0] tbs;
   logic [22:0] tds;

   // division by a thousand through a reciprocal
   always_comb begin
      vl  = nl_ff[45:AMP_SHIFT];
      vb  = nb_ff[45:AMP_SHIFT];
      tl  = ql_ff[61:DIV1000_SHIFT];
      tb  = qb_ff[61:DIV1000_SHIFT];
      tls = neg_f_ff[0] ? -$signed({3'b0, tl}) : $signed({3'b0, tl});
      tbs = neg_f_ff[1] ? -$signed(20'(tb)) : $signed(20'(tb));
      tds = neg_f_ff[2] ? DIST_BASE + 23'(td_ff) : DIST_BASE - 23'(td_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // products and rounding offsets
         jd2_e_ff <= jd2;
         neg_e_ff <= {neg_c, neg_f, neg_m};
         lonp_ff  <= 41'(la) * 41'd360;
         nl_ff    <= 46'(mag_m) * 46'(AMP_LON) + HALF_ROUND;
         nb_ff    <= 46'(mag_f) * 46'(AMP_LAT) + HALF_ROUND;
         nd_ff    <= 47'(mag_c) * 47'(AMP_DIST) + DIST_ROUND;
         // reciprocal products
         jd2_f_ff <= jd2_e_ff;
         neg_f_ff <= neg_e_ff;
         ql_ff    <= 62'(vl) * 62'(DIV1000_MUL);
         qb_ff    <= 62'(vb) * 62'(DIV1000_MUL);
         lonq_ff  <= lonp_ff[LON_SHIFT +: 25];
         td_ff    <= nd_ff[46:DIST_SHIFT];
         // signed results
         jd2_out  <= jd2_f_ff;
         lon      <= $signed({1'b0, lonq_ff}) + tls;
         lat      <= tbs;
         distance <= tds;
      end
   end

   assign out_valid = v_ff[2];

endmodule

### sim/lunar_position_from_date_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lunar_position_from_date_top_tb
// Drives calendar dates into the lunar position pipeline with random gaps and
// response stalls. Every response is checked field by field against an
// in-bench fixed-point model of the date arithmetic and the sine terms.
// ----------------------------------------------------------------------------
module lunar_position_from_date_top_tb;
   import lpd_pkg::*;

   localparam int NUM_RANDOM   = 1630;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [23:0]        jd2;
      logic signed [25:0] lon;
      logic signed [19:0] lat;
      logic [22:0]        distance;
   } moon_pos_type;

   typedef struct {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      bit          has_jd2;
      logic [23:0] jd2;
   } date_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lpd_req_if req_ch ();
   lpd_rsp_if rsp_ch ();

   moon_pos_type pending_positions [$];
   int           mismatches = 0;
   bit           stall_enable = 1'b1;

   lunar_position_from_date_top u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // binary fraction of a turn by long division
   function automatic longint unsigned turn_fraction(longint unsigned num,
                                                     longint unsigned den);
      longint unsigned r;
      longint unsigned q;
      r = num % den;
      q = 0;
      for (int i = 0; i < 64; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   // quarter-wave folded sine, Q30
   function automatic longint moon_sine(logic [31:0] a);
      logic [1:0]      quad;
      longint unsigned r;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned p;
      quad = a[31:30];
      r    = a[29:0];
      x    = quad[0] ? 64'd1073741824 - r : r;
      x2   = (x * x) >> 30;
      p    = 3864;
      p    = 172272     - ((x2 * p) >> 30);
      p    = 5026995    - ((x2 * p) >> 30);
      p    = 85569306   - ((x2 * p) >> 30);
      p    = 693598668  - ((x2 * p) >> 30);
      p    = 1686629713 - ((x2 * p) >> 30);
      p    = (x * p) >> 30;
      return quad[1] ? -longint'(p) : longint'(p);
   endfunction

   // amplitude term, rounded half away from zero
   function automatic longint scaled_term(longint s, longint unsigned k,
                                          longint unsigned den, int fb);
      longint unsigned mag;
      longint unsigned dv;
      longint unsigned v;
      mag = (s < 0) ? longint'(-s) : s;
      dv  = den << (30 - fb);
      v   = (mag * k + dv / 2) / dv;
      return (s < 0) ? -longint'(v) : longint'(v);
   endfunction

   function automatic logic [31:0] mean_phase(longint unsigned h, longint unsigned offn,
                                              longint unsigned raten);
      longint unsigned ph;
      ph = turn_fraction(offn, 360000) + h * turn_fraction(raten, 720000000);
      return ph[63:32];
   endfunction

   // expected position for one date
   function automatic moon_pos_type predict_position(logic [13:0] year, logic [3:0] month,
                                                     logic [4:0] day);
      longint          y;
      longint          m;
      longint          cent;
      longint          corr;
      longint          jd2;
      longint          h;
      longint          lon;
      longint          lat;
      longint          distance;
      logic [31:0]     la;
      logic [31:0]     ma;
      logic [31:0]     fa;
      longint unsigned lonq;
      moon_pos_type    res;
      y = year;
      m = month;
      if (m <= 2) begin
         y = y - 1;
         m = m + 12;
      end
      cent = (y >= 0) ? y / 100 : 0;
      corr = 2 - cent + cent / 4;
      jd2  = 2 * ((1461 * (y + 4716)) / 4 + (306001 * (m + 1)) / 10000 + day + corr)
             - 3049;
      h    = jd2 - 4903090;
      la   = mean_phase(h, 218316, 13176396);
      ma   = mean_phase(h, 134963, 13064993);
      fa   = mean_phase(h, 93272, 13229350);
      lonq = (longint'(la) * 360) >> 16;
      lon  = longint'(lonq) + scaled_term(moon_sine(ma), 6289, 1000, 16);
      lat  = scaled_term(moon_sine(fa), 5128, 1000, 16);
      distance = 385001 * 16 - scaled_term(moon_sine(ma + 32'h4000_0000), 20905, 1, 4);
      res.jd2      = jd2[23:0];
      res.lon      = lon[25:0];
      res.lat      = lat[19:0];
      res.distance = distance[22:0];
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!stall_enable || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   // request driver: holds valid across back-to-back requests
   task automatic send_date(logic [13:0] year, logic [3:0] month, logic [4:0] day,
                            bit has_jd2, logic [23:0] jd2);
      int           gap;
      moon_pos_type want;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.year  <= year;
      req_ch.month <= month;
      req_ch.day   <= day;
      do @(posedge clock); while (!req_ch.ready);
      want = predict_position(year, month, day);
      if (has_jd2) want.jd2 = jd2;
      pending_positions.push_back(want);
   endtask

   // response stalls
   always @(posedge clock) begin
      rsp_ch.ready <= (pick_gap() == 0);
   end

   // response checker
   always @(posedge clock) begin
      moon_pos_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_positions.size() == 0) begin
            report_mismatch("unexpected response", rsp_ch.julian_date_doubled, 0);
         end else begin
            want = pending_positions.pop_front();
            if (rsp_ch.julian_date_doubled !== want.jd2)
               report_mismatch("julian_date_doubled", rsp_ch.julian_date_doubled, want.jd2);
            if (rsp_ch.ecliptic_longitude !== want.lon)
               report_mismatch("ecliptic_longitude", rsp_ch.ecliptic_longitude, want.lon);
            if (rsp_ch.ecliptic_latitude !== want.lat)
               report_mismatch("ecliptic_latitude", rsp_ch.ecliptic_latitude, want.lat);
            if (rsp_ch.moon_distance !== want.distance)
               report_mismatch("moon_distance", rsp_ch.moon_distance, want.distance);
         end
      end
   end

   // directed dates; the epoch row carries its known doubled Julian date
   date_row_type directed_dates [] = '{
      '{14'd2000,  4'd1,  5'd1,  1'b1, 24'd4903089},
      '{14'd1,     4'd1,  5'd1,  1'b0, 24'd0},
      '{14'd9999,  4'd12, 5'd31, 1'b0, 24'd0},
      '{14'd0,     4'd1,  5'd1,  1'b0, 24'd0},
      '{14'd0,     4'd2,  5'd28, 1'b0, 24'd0},
      '{14'd0,     4'd0,  5'd0,  1'b0, 24'd0},
      '{14'd1999,  4'd0,  5'd15, 1'b0, 24'd0},
      '{14'd2024,  4'd13, 5'd1,  1'b0, 24'd0},
      '{14'd2024,  4'd14, 5'd10, 1'b0, 24'd0},
      '{14'd2024,  4'd15, 5'd31, 1'b0, 24'd0},
      '{14'd1900,  4'd3,  5'd0,  1'b0, 24'd0},
      '{14'd1582,  4'd2,  5'd31, 1'b0, 24'd0},
      '{14'd2100,  4'd3,  5'd1,  1'b0, 24'd0},
      '{14'd16383, 4'd15, 5'd31, 1'b0, 24'd0},
      '{14'd16383, 4'd1,  5'd0,  1'b0, 24'd0},
      '{14'd10922, 4'd10, 5'd21, 1'b0, 24'd0},
      '{14'd5461,  4'd5,  5'd10, 1'b0, 24'd0},
      '{14'd2000,  4'd3,  5'd20, 1'b0, 24'd0},
      '{14'd1969,  4'd7,  5'd20, 1'b0, 24'd0}
   };

   // run limit
   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // stimulus and end of run
   initial begin
      req_ch.valid = 1'b0;
      req_ch.year  = '0;
      req_ch.month = '0;
      req_ch.day   = '0;
      rsp_ch.ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_dates[i])
         send_date(directed_dates[i].year, directed_dates[i].month,
                   directed_dates[i].day, directed_dates[i].has_jd2,
                   directed_dates[i].jd2);

      for (int i = 0; i < NUM_RANDOM; i++) begin
         // alternate stretches with and without idling
         if (i % 200 == 0) stall_enable = (i % 400 == 0);
         send_date(14'($urandom), 4'($urandom), 5'($urandom), 1'b0, 24'd0);
      end
      stall_enable = 1'b1;
      req_ch.valid <= 1'b0;

      while (pending_positions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
